@@ hdl/dmsn_pkg.sv @@
package dmsn_pkg;

	// fixed field and datapath widths
	localparam int ELEM_W = 32;
	localparam int S_W    = 48;
	localparam int Q_W    = 64;
	localparam int ACC_W  = Q_W + S_W;
	localparam int E_W    = 96;
	localparam int T_W    = 104;
	localparam int N_W    = 13;
	localparam int F_W    = 16;
	localparam int FEAT_W = 2 * F_W;
	localparam int TQ_W   = 33;
	localparam int QUO_W  = 31;
	localparam int K_W    = 7;
	localparam int DIM_W  = 6;

	// 0.4 in unsigned Q1.15
	localparam logic [F_W-1:0] CLAMP_Q15 = 16'd13107;

	typedef struct packed {
		logic [ELEM_W-1:0] element_value;
		logic              last_element;
	} item_t;

	typedef struct packed {
		logic [DIM_W-1:0] dim_index;
		logic [F_W-1:0]   mean_feature;
		logic [F_W-1:0]   std_feature;
		logic             last_result;
	} result_t;

	// commands into the normalize unit
	typedef struct packed {
		logic load;
		logic start;
	} norm_ctl_t;

	typedef enum logic [1:0] {
		NS_IDLE,
		NS_SEARCH,
		NS_DIV,
		NS_SQRT
	} norm_state_t;

	typedef enum logic [1:0] {
		PASS_SUM,
		PASS_MEAN,
		PASS_STD,
		PASS_GLOB
	} pass_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_RD,
		ST_EGO,
		ST_ENERGY,
		ST_TOTAL,
		ST_NLOAD,
		ST_NWAIT,
		ST_DIV,
		ST_CLAMP,
		ST_WRITE,
		ST_GRD,
		ST_GSQ,
		ST_GGO,
		ST_GDIV,
		ST_GWR,
		ST_OUT,
		ST_CLEAR
	} fin_state_t;

endpackage

@@ hdl/descriptor_mean_std_normalize.sv @@
// Mean/std descriptor normalizer.
// Items enter on start/item while busy is low, one element per cycle, row-major,
// DIMS elements to a row; last_element marks the final element of the matrix.
// Elements are summed and squared into a per-dimension accumulator memory through
// a three-stage read-modify-write pipeline, so loading runs at one item per cycle.
// The item with last_element raises busy. The block then drains the pipeline and
// makes four passes over the memories: energy totals, mean features, std features
// and the final joint normalization, each divide and square root running in one
// shared unit, which also does the three norm shift searches.
// Results then leave one per cycle, dimension 0 first, each on result for a single
// cycle with strobe high; last_result marks dimension DIMS-1. The receiver cannot
// stall the block, so results must be taken as they come. busy falls in the cycle after
// the last result, and the accumulators are empty again for the next matrix.
// Reset clears all control state and the per-entry valid bits, so the accumulators
// read as zero without a clearing pass and an item can be taken right after reset.
module descriptor_mean_std_normalize #(
	parameter int DIMS     = 36,
	parameter int MAX_ROWS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  dmsn_pkg::item_t   item,
	output logic              busy,
	output logic              strobe,
	output dmsn_pkg::result_t result
);
	import dmsn_pkg::*;

	localparam int DW = $clog2(DIMS);
	localparam int RW = $clog2(MAX_ROWS + 1);

	fin_state_t       state_q;
	fin_state_t       state_d;
	pass_t            pass_q;
	logic [DW-1:0]    idx_q;
	logic             half_q;
	logic [DW-1:0]    dim_q;
	logic [RW-1:0]    row_q;
	logic [DIMS-1:0]  valid_q;
	logic             ov_q;
	logic [DW-1:0]    oidx_q;

	// load pipeline
	logic             v_s1;
	logic [ELEM_W-1:0] x_s1;
	logic [DW-1:0]    d_s1;
	logic             v_s2;
	logic [ELEM_W-1:0] x_s2;
	logic [DW-1:0]    d_s2;
	logic [S_W-1:0]   s_s2;
	logic [Q_W-1:0]   q_s2;
	logic [S_W-1:0]   sq_s2;

	// finalize datapath
	logic [T_W-1:0]   tm_q;
	logic [T_W-1:0]   ts_q;
	logic [T_W-1:0]   tg_q;
	logic [F_W-1:0]   fm_q;
	logic [F_W-1:0]   fc_q;
	logic [F_W-1:0]   gm_q;
	logic [FEAT_W-1:0] sq_q;

	logic             accept;
	logic             acc_ok;
	logic             dim_wrap;
	logic             last_idx;
	logic [63:0]      x_sq;
	logic             acc_re;
	logic [DW-1:0]    acc_raddr;
	logic [ACC_W-1:0] acc_rd;
	logic [ACC_W-1:0] acc_wdata;
	logic             fin_acc_re;
	logic             feat_re;
	logic             feat_we;
	logic [FEAT_W-1:0] feat_rd;
	logic [FEAT_W-1:0] feat_wdata;
	logic             ent_valid;
	logic             eng_start;
	logic             eng_done;
	logic [E_W-1:0]   eng_em;
	logic [E_W-1:0]   eng_es;
	norm_ctl_t        norm_ctl;
	logic             norm_done;
	logic [F_W-1:0]   norm_feature;
	logic [T_W-1:0]   norm_total;
	logic [T_W-1:0]   norm_energy;
	logic [F_W-1:0]   fc;
	logic [F_W-1:0]   sq_in;
	logic [FEAT_W-1:0] sq_out;

	assign busy     = state_q != ST_IDLE;
	assign accept   = start && !busy;
	assign acc_ok   = row_q < RW'(MAX_ROWS);
	assign dim_wrap = item.last_element || (dim_q == DW'(DIMS - 1));
	assign last_idx = idx_q == DW'(DIMS - 1);

	// accumulator memory: {square sum, sum}
	assign acc_re    = (accept && acc_ok) || fin_acc_re;
	assign acc_raddr = (state_q == ST_IDLE) ? dim_q : idx_q;
	assign acc_wdata = {q_s2 + Q_W'(sq_s2), s_s2 + S_W'(x_s2)};

	dmsn_ram #(
		.WIDTH(ACC_W),
		.DEPTH(DIMS)
	) u_acc_ram (
		.clk  (clk),
		.we   (v_s2),
		.waddr(d_s2),
		.wdata(acc_wdata),
		.re   (acc_re),
		.raddr(acc_raddr),
		.rdata(acc_rd)
	);

	// feature memory, later the result buffer: {std, mean}
	dmsn_ram #(
		.WIDTH(FEAT_W),
		.DEPTH(DIMS)
	) u_feat_ram (
		.clk  (clk),
		.we   (feat_we),
		.waddr(idx_q),
		.wdata(feat_wdata),
		.re   (feat_re),
		.raddr(idx_q),
		.rdata(feat_rd)
	);

	assign ent_valid = valid_q[idx_q];

	dmsn_energy u_energy (
		.clk   (clk),
		.arst_n(arst_n),
		.start (eng_start),
		.s     (ent_valid ? acc_rd[S_W-1:0] : '0),
		.q     (ent_valid ? acc_rd[ACC_W-1:S_W] : '0),
		.n     (N_W'(row_q)),
		.done  (eng_done),
		.em    (eng_em),
		.es    (eng_es)
	);

	// operand select for the normalize unit
	always_comb begin
		case (pass_q)
			PASS_MEAN: norm_total = tm_q;
			PASS_STD:  norm_total = ts_q;
			default:   norm_total = tg_q;
		endcase
		if (state_q == ST_GGO) begin
			norm_energy = T_W'(sq_q);
		end else if (pass_q == PASS_MEAN) begin
			norm_energy = T_W'(eng_em);
		end else begin
			norm_energy = T_W'(eng_es);
		end
	end

	dmsn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (norm_ctl),
		.total  (norm_total),
		.energy (norm_energy),
		.done   (norm_done),
		.feature(norm_feature)
	);

	// clamp and the shared feature squarer
	assign fc     = (norm_feature > CLAMP_Q15) ? CLAMP_Q15 : norm_feature;
	assign sq_in  = (state_q == ST_GSQ) ? (half_q ? feat_rd[FEAT_W-1:F_W] : feat_rd[F_W-1:0])
		: fc;
	assign sq_out = sq_in * sq_in;

	always_comb begin
		if (state_q == ST_GWR) begin
			feat_wdata = {norm_feature, gm_q};
		end else if (pass_q == PASS_MEAN) begin
			feat_wdata = {{F_W{1'b0}}, fc_q};
		end else begin
			feat_wdata = {fc_q, fm_q};
		end
	end

	assign x_sq = x_s1 * x_s1;

	// finalize sequencer: next state and strobes
	always_comb begin
		state_d    = state_q;
		eng_start  = 1'b0;
		norm_ctl   = '0;
		fin_acc_re = 1'b0;
		feat_re    = 1'b0;
		feat_we    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && item.last_element) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				fin_acc_re = 1'b1;
				feat_re    = 1'b1;
				state_d    = ST_EGO;
			end
			ST_EGO: begin
				eng_start = 1'b1;
				state_d   = ST_ENERGY;
			end
			ST_ENERGY: begin
				if (eng_done) begin
					if (pass_q == PASS_SUM) begin
						state_d = ST_TOTAL;
					end else begin
						norm_ctl.start = 1'b1;
						state_d        = ST_DIV;
					end
				end
			end
			ST_TOTAL: begin
				state_d = last_idx ? ST_NLOAD : ST_RD;
			end
			ST_NLOAD: begin
				norm_ctl.load = 1'b1;
				state_d       = ST_NWAIT;
			end
			ST_NWAIT: begin
				if (norm_done) begin
					state_d = (pass_q == PASS_GLOB) ? ST_GRD : ST_RD;
				end
			end
			ST_DIV: begin
				if (norm_done) begin
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				feat_we = 1'b1;
				state_d = last_idx ? ST_NLOAD : ST_RD;
			end
			ST_GRD: begin
				feat_re = 1'b1;
				state_d = ST_GSQ;
			end
			ST_GSQ: begin
				state_d = ST_GGO;
			end
			ST_GGO: begin
				norm_ctl.start = 1'b1;
				state_d        = ST_GDIV;
			end
			ST_GDIV: begin
				if (norm_done) begin
					state_d = half_q ? ST_GWR : ST_GSQ;
				end
			end
			ST_GWR: begin
				feat_we = 1'b1;
				state_d = last_idx ? ST_OUT : ST_GRD;
			end
			ST_OUT: begin
				feat_re = 1'b1;
				state_d = last_idx ? ST_CLEAR : ST_OUT;
			end
			ST_CLEAR: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= PASS_SUM;
			idx_q   <= '0;
			half_q  <= 1'b0;
			dim_q   <= '0;
			row_q   <= '0;
			valid_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			ov_q    <= 1'b0;
			oidx_q  <= '0;
		end else begin
			state_q <= state_d;
			ov_q    <= state_q == ST_OUT;
			oidx_q  <= idx_q;

			// row and column position of the incoming item
			if (accept) begin
				if (dim_wrap) begin
					dim_q <= '0;
					if (acc_ok) begin
						row_q <= row_q + RW'(1);
					end
				end else begin
					dim_q <= dim_q + DW'(1);
				end
			end
			v_s1 <= accept && acc_ok;
			v_s2 <= v_s1;
			if (v_s2) begin
				valid_q[d_s2] <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && item.last_element) begin
						pass_q <= PASS_SUM;
						idx_q  <= '0;
					end
				end
				ST_TOTAL: begin
					if (last_idx) begin
						idx_q  <= '0;
						pass_q <= PASS_MEAN;
					end else begin
						idx_q <= idx_q + DW'(1);
					end
				end
				ST_WRITE: begin
					if (last_idx) begin
						idx_q  <= '0;
						pass_q <= (pass_q == PASS_MEAN) ? PASS_STD : PASS_GLOB;
					end else begin
						idx_q <= idx_q + DW'(1);
					end
				end
				ST_GRD: begin
					half_q <= 1'b0;
				end
				ST_GDIV: begin
					if (norm_done) begin
						half_q <= 1'b1;
					end
				end
				ST_GWR, ST_OUT: begin
					idx_q <= last_idx ? '0 : idx_q + DW'(1);
				end
				ST_CLEAR: begin
					dim_q   <= '0;
					row_q   <= '0;
					valid_q <= '0;
				end
				default: begin
					half_q <= half_q;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// load pipeline: read, square, add and write back
		x_s1  <= item.element_value;
		d_s1  <= dim_q;
		x_s2  <= x_s1;
		d_s2  <= d_s1;
		sq_s2 <= x_sq[63:16];
		s_s2  <= valid_q[d_s1] ? acc_rd[S_W-1:0] : '0;
		q_s2  <= valid_q[d_s1] ? acc_rd[ACC_W-1:S_W] : '0;

		case (state_q)
			ST_IDLE: begin
				tm_q <= '0;
				ts_q <= '0;
				tg_q <= '0;
			end
			ST_EGO: begin
				fm_q <= feat_rd[F_W-1:0];
			end
			ST_TOTAL: begin
				tm_q <= tm_q + T_W'(eng_em);
				ts_q <= ts_q + T_W'(eng_es);
			end
			ST_CLAMP: begin
				fc_q <= fc;
				sq_q <= sq_out;
			end
			ST_WRITE: begin
				tg_q <= tg_q + T_W'(sq_q);
			end
			ST_GSQ: begin
				sq_q <= sq_out;
			end
			ST_GDIV: begin
				if (norm_done && !half_q) begin
					gm_q <= norm_feature;
				end
			end
			default: begin
				fc_q <= fc_q;
			end
		endcase
	end

	// result port
	assign strobe              = ov_q;
	assign result.dim_index    = DIM_W'(oidx_q);
	assign result.mean_feature = feat_rd[F_W-1:0];
	assign result.std_feature  = feat_rd[FEAT_W-1:F_W];
	assign result.last_result  = oidx_q == DW'(DIMS - 1);

`ifndef SYNTH
	// a write-back never meets a read of the same entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && acc_re) |-> (acc_raddr != d_s2))
		else $error("accumulator read collides with write-back");

	// results only come out of a finalize run
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result strobe while idle");

	// the last result closes the burst
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last_result) |=> !strobe)
		else $error("result after the last dimension");

	// finalize starts only with an empty load pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (!v_s1 && !v_s2))
		else $error("finalize read before pipeline drained");
`endif

endmodule

@@ hdl/dmsn_ram.sv @@
module dmsn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/dmsn_energy.sv @@
module dmsn_energy (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [dmsn_pkg::S_W-1:0] s,
	input  logic [dmsn_pkg::Q_W-1:0] q,
	input  logic [dmsn_pkg::N_W-1:0] n,
	output logic                    done,
	output logic [dmsn_pkg::E_W-1:0] em,
	output logic [dmsn_pkg::E_W-1:0] es
);
	import dmsn_pkg::*;

	// partial product schedule
	localparam logic [2:0] MS_HI_HI = 3'd0;
	localparam logic [2:0] MS_HI_LO = 3'd1;
	localparam logic [2:0] MS_LO_LO = 3'd2;
	localparam logic [2:0] MS_N_QHI = 3'd3;
	localparam logic [2:0] MS_N_QLO = 3'd4;
	localparam logic [2:0] MS_ADD   = 3'd5;
	localparam logic [2:0] MS_END   = 3'd6;

	logic           run_q;
	logic [2:0]     step_q;
	logic           done_q;
	logic [S_W-1:0] s_q;
	logic [Q_W-1:0] q_q;
	logic [N_W-1:0] n_q;
	logic [S_W-1:0] prod_q;
	logic [2:0]     pstep_q;
	logic [E_W-1:0] sqa_q;
	logic [E_W-1:0] aa_q;
	logic [E_W-1:0] em_q;
	logic [E_W-1:0] es_q;

	logic [31:0]    ma;
	logic [31:0]    mb;
	logic [63:0]    mul;
	logic [E_W-1:0] addend;

	// operand select for the shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		case (step_q)
			MS_HI_HI: begin
				ma = 32'(s_q[S_W-1:24]);
				mb = 32'(s_q[S_W-1:24]);
			end
			MS_HI_LO: begin
				ma = 32'(s_q[S_W-1:24]);
				mb = 32'(s_q[23:0]);
			end
			MS_LO_LO: begin
				ma = 32'(s_q[23:0]);
				mb = 32'(s_q[23:0]);
			end
			MS_N_QHI: begin
				ma = 32'(n_q);
				mb = q_q[Q_W-1:32];
			end
			MS_N_QLO: begin
				ma = 32'(n_q);
				mb = q_q[31:0];
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign mul = ma * mb;

	// align the previous product
	always_comb begin
		case (pstep_q)
			MS_HI_HI: addend = {prod_q, 48'd0};
			MS_HI_LO: addend = E_W'(prod_q) << 25;
			MS_LO_LO: addend = E_W'(prod_q);
			MS_N_QHI: addend = {prod_q, 48'd0};
			MS_N_QLO: addend = E_W'(prod_q) << 16;
			default:  addend = '0;
		endcase
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (step_q == MS_END);
			if (start) begin
				run_q  <= 1'b1;
				step_q <= MS_HI_HI;
			end else if (run_q) begin
				if (step_q == MS_END) begin
					run_q <= 1'b0;
				end
				step_q <= step_q + 3'd1;
			end
		end
	end

	// multiply, accumulate, subtract
	always_ff @(posedge clk) begin
		if (start) begin
			s_q   <= s;
			q_q   <= q;
			n_q   <= n;
			sqa_q <= '0;
			aa_q  <= '0;
		end else if (run_q) begin
			if (step_q <= MS_N_QLO) begin
				prod_q  <= mul[S_W-1:0];
				pstep_q <= step_q;
			end
			if (step_q >= MS_HI_LO && step_q <= MS_ADD) begin
				if (pstep_q <= MS_LO_LO) begin
					sqa_q <= sqa_q + addend;
				end else begin
					aa_q <= aa_q + addend;
				end
			end
			if (step_q == MS_END) begin
				em_q <= sqa_q;
				es_q <= (aa_q >= sqa_q) ? aa_q - sqa_q : '0;
			end
		end
	end

	assign done = done_q;
	assign em   = em_q;
	assign es   = es_q;

endmodule

@@ hdl/dmsn_norm.sv @@
module dmsn_norm (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dmsn_pkg::norm_ctl_t       ctl,
	input  logic [dmsn_pkg::T_W-1:0]  total,
	input  logic [dmsn_pkg::T_W-1:0]  energy,
	output logic                      done,
	output logic [dmsn_pkg::F_W-1:0]  feature
);
	import dmsn_pkg::*;

	norm_state_t      state_q;
	norm_state_t      state_d;
	logic             done_q;
	logic             done_d;
	logic [T_W-1:0]   tot_q;
	logic [K_W-1:0]   k_q;
	logic             zero_q;
	logic [TQ_W:0]    rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [4:0]       cnt_q;
	logic [F_W-1:0]   root_q;

	logic [T_W-1:0]   e_shift;
	logic [TQ_W-1:0]  tq;
	logic             rem_ge;
	logic [TQ_W:0]    rem_sub;
	logic [F_W-1:0]   trial;
	logic [2*F_W-1:0] trial_sq;
	logic             search_more;

	assign tq          = tot_q[TQ_W-1:0];
	assign e_shift     = energy >> k_q;
	assign rem_ge      = rem_q >= {1'b0, tq};
	assign rem_sub     = rem_ge ? rem_q - {1'b0, tq} : rem_q;
	assign trial       = root_q | (F_W'(1) << cnt_q[3:0]);
	assign trial_sq    = trial * trial;
	assign search_more = tot_q[T_W-1:TQ_W] != '0;

	// next state
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		case (state_q)
			NS_IDLE: begin
				if (ctl.load) begin
					state_d = NS_SEARCH;
				end else if (ctl.start) begin
					if (zero_q) begin
						done_d = 1'b1;
					end else begin
						state_d = NS_DIV;
					end
				end
			end
			NS_SEARCH: begin
				if (!search_more) begin
					state_d = NS_IDLE;
					done_d  = 1'b1;
				end
			end
			NS_DIV: begin
				if (cnt_q == '0) begin
					state_d = NS_SQRT;
				end
			end
			NS_SQRT: begin
				if (cnt_q == '0) begin
					state_d = NS_IDLE;
					done_d  = 1'b1;
				end
			end
			default: state_d = NS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= NS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// shift search, restoring divide, bitwise root
	always_ff @(posedge clk) begin
		case (state_q)
			NS_IDLE: begin
				if (ctl.load) begin
					tot_q  <= total;
					k_q    <= '0;
					zero_q <= total == '0;
				end else if (ctl.start) begin
					rem_q  <= {1'b0, e_shift[TQ_W-1:0]};
					quo_q  <= '0;
					cnt_q  <= 5'(QUO_W - 1);
					root_q <= '0;
				end
			end
			NS_SEARCH: begin
				if (search_more) begin
					tot_q <= tot_q >> 1;
					k_q   <= k_q + K_W'(1);
				end
			end
			NS_DIV: begin
				quo_q <= {quo_q[QUO_W-2:0], rem_ge};
				rem_q <= {rem_sub[TQ_W-1:0], 1'b0};
				cnt_q <= (cnt_q == '0) ? 5'(F_W - 1) : cnt_q - 5'd1;
			end
			NS_SQRT: begin
				if (trial_sq <= 32'(quo_q)) begin
					root_q <= trial;
				end
				cnt_q <= cnt_q - 5'd1;
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	assign done    = done_q;
	assign feature = root_q;

endmodule
